// ===== hw/rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions for the stable priority queue
// Opcodes, default sizes, the configuration register format and the control
// bundle that the top level broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEFAULT_DEPTH         = 16;
  localparam int DEFAULT_PAYLOAD_WIDTH = 32;
  localparam int PRIO_WIDTH            = 64;
  localparam int OPCODE_WIDTH          = 2;
  localparam int CAP_WIDTH             = 5;
  localparam logic [CAP_WIDTH-1:0] CAP_RESET = CAP_WIDTH'(16);

  typedef enum logic [OPCODE_WIDTH-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PEEK   = 2'd2
  } spq_opcode_t;

  typedef enum logic {
    ST_OK    = 1'b0,
    ST_ERROR = 1'b1
  } spq_status_t;

  // Per-cycle command for the cell row.
  typedef struct packed {
    logic ins;  // sorted insert of the broadcast entry
    logic rem;  // pop the head, every cell takes its right neighbor
  } spq_ctrl_t;

endpackage

// ===== hw/rtl/spq_in_if.sv =====
// ----------------------------------------------------------------------------
// spq_in_if: operation channel of the stable priority queue
// Valid/ready channel carrying one opcode, payload and priority per beat.
// ----------------------------------------------------------------------------
interface spq_in_if
  import spq_pkg::*;
#(
  parameter int PAYLOAD_WIDTH = DEFAULT_PAYLOAD_WIDTH
) ();
  logic                           valid;
  logic                           ready;
  logic [OPCODE_WIDTH-1:0]        opcode;
  logic [PAYLOAD_WIDTH-1:0]       in_payload;
  logic signed [PRIO_WIDTH-1:0]   in_priority;

  modport source (output valid, opcode, in_payload, in_priority, input ready);
  modport sink   (input valid, opcode, in_payload, in_priority, output ready);
endinterface

// ===== hw/rtl/spq_out_if.sv =====
// ----------------------------------------------------------------------------
// spq_out_if: result channel of the stable priority queue
// Valid/ready channel carrying status, head entry, count and flags per beat.
// ----------------------------------------------------------------------------
interface spq_out_if
  import spq_pkg::*;
#(
  parameter int PAYLOAD_WIDTH = DEFAULT_PAYLOAD_WIDTH,
  parameter int COUNT_WIDTH   = $clog2(DEFAULT_DEPTH + 1)
) ();
  logic                           valid;
  logic                           ready;
  logic                           status;
  logic [PAYLOAD_WIDTH-1:0]       out_payload;
  logic signed [PRIO_WIDTH-1:0]   out_priority;
  logic [COUNT_WIDTH-1:0]         entry_count;
  logic                           is_empty;
  logic                           is_full;

  modport source (output valid, status, out_payload, out_priority, entry_count,
                  is_empty, is_full, input ready);
  modport sink   (input valid, status, out_payload, out_priority, entry_count,
                  is_empty, is_full, output ready);
endinterface

// ===== hw/rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted entry row
// Holds one entry, compares it with the broadcast priority and takes data
// from the new entry, its left neighbor or its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
#(
  parameter int PAYLOAD_WIDTH = DEFAULT_PAYLOAD_WIDTH
) (
  input  logic                         clk,
  input  spq_ctrl_t                    ctrl,
  input  logic                         slot_valid,
  input  logic [PAYLOAD_WIDTH-1:0]     new_payload,
  input  logic signed [PRIO_WIDTH-1:0] new_priority,
  input  logic                         left_gt,
  input  logic [PAYLOAD_WIDTH-1:0]     left_payload,
  input  logic signed [PRIO_WIDTH-1:0] left_priority,
  input  logic [PAYLOAD_WIDTH-1:0]     right_payload,
  input  logic signed [PRIO_WIDTH-1:0] right_priority,
  output logic                         gt,
  output logic [PAYLOAD_WIDTH-1:0]     payload,
  output logic signed [PRIO_WIDTH-1:0] priority_val
);

  logic [PAYLOAD_WIDTH-1:0]     payload_r, payload_nxt;
  logic signed [PRIO_WIDTH-1:0] priority_r, priority_nxt;

  // An empty slot counts as greater, so the row reads as one sorted run.
  // Equal priorities are not greater, which keeps arrival order.
  assign gt = !slot_valid || (priority_r > new_priority);

  always_comb begin
    payload_nxt  = payload_r;
    priority_nxt = priority_r;
    if (ctrl.ins && gt) begin
      if (left_gt) begin
        payload_nxt  = left_payload;
        priority_nxt = left_priority;
      end else begin
        payload_nxt  = new_payload;
        priority_nxt = new_priority;
      end
    end else if (ctrl.rem) begin
      payload_nxt  = right_payload;
      priority_nxt = right_priority;
    end
  end

  always_ff @(posedge clk) begin
    payload_r  <= payload_nxt;
    priority_r <= priority_nxt;
  end

  assign payload      = payload_r;
  assign priority_val = priority_r;

endmodule

// ===== hw/rtl/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded stable minimum priority queue
// Sorted row of compare-and-shift cells with a registered result beat.
// ----------------------------------------------------------------------------
// The queue takes one operation beat per clock cycle (insert, remove head,
// peek head) and returns exactly one result beat for each, in the next cycle,
// through an output register; a new operation is taken in the same cycle
// that the pending result is taken, so the sustained rate is one beat per
// cycle. Entries live in a row of DEPTH cells kept in ascending signed
// priority order, slot 0 being the head. On an insert every cell compares
// its own priority with the new one in parallel, and the cells at and
// beyond the insertion point each take their left neighbor's entry while
// the first of them takes the new entry; a remove makes every cell take its
// right neighbor. Entries of equal priority leave in arrival order. Insert
// on a full queue and remove or peek on an empty one report an error and
// change nothing. The capacity register limits how many entries are held:
// zero acts as one and values above DEPTH act as DEPTH; lowering it below
// the current count keeps the entries, which can still be removed.
// ----------------------------------------------------------------------------
module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH         = DEFAULT_DEPTH,
  parameter int PAYLOAD_WIDTH = DEFAULT_PAYLOAD_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  spq_in_if.sink               in_ch,
  spq_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CAP_WIDTH-1:0] cfg_wdata
);

  localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
  // Width that holds both the count and the raw capacity register.
  localparam int CMP_WIDTH   = (COUNT_WIDTH > CAP_WIDTH) ? COUNT_WIDTH : CAP_WIDTH;

  // Capacity register and entry count.
  logic [CAP_WIDTH-1:0]   cap_r;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;

  // Result register.
  logic                         out_valid_r, out_valid_nxt;
  logic                         status_r, status_nxt;
  logic [PAYLOAD_WIDTH-1:0]     out_payload_r, out_payload_nxt;
  logic signed [PRIO_WIDTH-1:0] out_priority_r, out_priority_nxt;
  logic                         is_full_r, is_full_nxt;

  // Cell row taps.
  logic                         cell_gt  [DEPTH];
  logic [PAYLOAD_WIDTH-1:0]     cell_pay [DEPTH];
  logic signed [PRIO_WIDTH-1:0] cell_pri [DEPTH];

  logic                 accept;
  logic [CMP_WIDTH-1:0] eff_cap;
  logic                 full_now;
  logic                 empty_now;
  spq_ctrl_t            ctrl;
  spq_opcode_t          op;

  // The input side only waits while a result is held and not being taken.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign op          = spq_opcode_t'(in_ch.opcode);

  // Effective capacity: zero behaves as one, anything past DEPTH as DEPTH.
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CMP_WIDTH'(1);
    end else if (CMP_WIDTH'(cap_r) > CMP_WIDTH'(DEPTH)) begin
      eff_cap = CMP_WIDTH'(DEPTH);
    end else begin
      eff_cap = CMP_WIDTH'(cap_r);
    end
  end

  assign full_now  = CMP_WIDTH'(count_r) >= eff_cap;
  assign empty_now = (count_r == '0);

  // Decode the operation, build the cell command and the result beat.
  always_comb begin
    ctrl             = '0;
    count_nxt        = count_r;
    status_nxt       = status_r;
    out_payload_nxt  = out_payload_r;
    out_priority_nxt = out_priority_r;
    out_valid_nxt    = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt    = 1'b1;
      status_nxt       = ST_OK;
      out_payload_nxt  = '0;
      out_priority_nxt = '0;
      case (op)
        OP_INSERT: begin
          if (full_now) begin
            status_nxt = ST_ERROR;
          end else begin
            ctrl.ins  = 1'b1;
            count_nxt = count_r + COUNT_WIDTH'(1);
          end
        end
        OP_REMOVE, OP_PEEK: begin
          if (empty_now) begin
            status_nxt = ST_ERROR;
          end else begin
            out_payload_nxt  = cell_pay[0];
            out_priority_nxt = cell_pri[0];
            if (op == OP_REMOVE) begin
              ctrl.rem  = 1'b1;
              count_nxt = count_r - COUNT_WIDTH'(1);
            end
          end
        end
        default: begin
          status_nxt = ST_ERROR;
        end
      endcase
    end
    // The full flag reports the count after this operation.
    is_full_nxt = (CMP_WIDTH'(count_nxt) >= eff_cap);
    if (!accept) begin
      is_full_nxt = is_full_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r       <= status_nxt;
    out_payload_r  <= out_payload_nxt;
    out_priority_r <= out_priority_nxt;
    is_full_r      <= is_full_nxt;
  end

  // The row of cells. A slot is occupied when its index is below the count.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                         left_gt;
    logic [PAYLOAD_WIDTH-1:0]     left_pay, right_pay;
    logic signed [PRIO_WIDTH-1:0] left_pri, right_pri;

    if (i == 0) begin : g_head
      // The head has no left neighbor; it takes the new entry when greater.
      assign left_gt  = 1'b0;
      assign left_pay = cell_pay[i];
      assign left_pri = cell_pri[i];
    end else begin : g_body
      assign left_gt  = cell_gt[i-1];
      assign left_pay = cell_pay[i-1];
      assign left_pri = cell_pri[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      // Nothing comes from beyond the tail; the slot becomes free anyway.
      assign right_pay = cell_pay[i];
      assign right_pri = cell_pri[i];
    end else begin : g_mid
      assign right_pay = cell_pay[i+1];
      assign right_pri = cell_pri[i+1];
    end

    spq_cell #(
      .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
    ) u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .slot_valid    (COUNT_WIDTH'(i) < count_r),
      .new_payload   (in_ch.in_payload),
      .new_priority  (in_ch.in_priority),
      .left_gt       (left_gt),
      .left_payload  (left_pay),
      .left_priority (left_pri),
      .right_payload (right_pay),
      .right_priority(right_pri),
      .gt            (cell_gt[i]),
      .payload       (cell_pay[i]),
      .priority_val  (cell_pri[i])
    );
  end

  // Result beat; count and empty flag follow the live count register,
  // which holds the value after the operation of the pending beat.
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.out_payload  = out_payload_r;
  assign out_ch.out_priority = out_priority_r;
  assign out_ch.entry_count  = count_r;
  assign out_ch.is_empty     = (count_r == '0);
  assign out_ch.is_full      = is_full_r;

  // The count never passes the number of built cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_WIDTH'(count_r) <= CMP_WIDTH'(DEPTH))
    else $error("entry count exceeds depth");

  // A successful insert grows the count by exactly one.
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ins |=> (count_r == $past(count_r) + COUNT_WIDTH'(1)))
    else $error("insert did not advance the count");

  // A peek leaves the count alone.
  a_peek_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == OP_PEEK) |=> $stable(count_r))
    else $error("peek changed the count");

  // The two front slots stay in ascending order.
  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (CMP_WIDTH'(count_r) >= CMP_WIDTH'(2)) |-> (cell_pri[0] <= cell_pri[1]))
    else $error("head slots out of order");

  // Only one row command can be active in a cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.ins && ctrl.rem))
    else $error("insert and remove issued together");

endmodule

// ===== test/stable_priority_queue_tb.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue_tb: self-checking bench for the stable priority queue
// Feeds insert, remove, peek and unused-opcode beats through the operation
// channel, rebuilds the sorted store alongside the design to predict every
// result beat, and checks each returned beat field by field. The run moves
// through several capacity settings and mixes of sender and receiver stalls.
// ----------------------------------------------------------------------------
module stable_priority_queue_tb;
  import spq_pkg::*;

  localparam int SLOTS = DEFAULT_DEPTH;
  // Opcode 3 has no meaning in the design; it must come back as an error.
  localparam logic [OPCODE_WIDTH-1:0] OP_UNUSED = 2'd3;
  localparam logic signed [PRIO_WIDTH-1:0] PRIO_MIN = {1'b1, {(PRIO_WIDTH-1){1'b0}}};
  localparam logic signed [PRIO_WIDTH-1:0] PRIO_MAX = {1'b0, {(PRIO_WIDTH-1){1'b1}}};

  // One operation beat as offered on the input channel.
  typedef struct {
    logic [OPCODE_WIDTH-1:0]      opcode;
    logic [31:0]                  payload;
    logic signed [PRIO_WIDTH-1:0] prio;
  } queue_op_t;

  // One result beat as the design should return it.
  typedef struct {
    logic                         status;
    logic [31:0]                  payload;
    logic signed [PRIO_WIDTH-1:0] prio;
    logic [CAP_WIDTH-1:0]         count;
    logic                         empty;
    logic                         full;
  } queue_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CAP_WIDTH-1:0] cfg_wdata = CAP_RESET;
  logic                 hold_results = 1'b0;

  spq_in_if  #(.PAYLOAD_WIDTH(32)) in_ch ();
  spq_out_if #(.PAYLOAD_WIDTH(32)) out_ch ();

  stable_priority_queue #(
    .DEPTH         (SLOTS),
    .PAYLOAD_WIDTH (32)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Stimulus waiting to be offered, and result beats still owed by the design.
  queue_op_t     queued_ops[$];
  queue_result_t awaited_results[$];

  // Shadow copy of the sorted store. Slot 0 is the head.
  logic [31:0]                  shadow_payload[SLOTS];
  logic signed [PRIO_WIDTH-1:0] shadow_prio[SLOTS];
  int                           shadow_held = 0;
  logic [CAP_WIDTH-1:0]         shadow_cap = CAP_RESET;

  // Stall rates in percent, changed only while the design is idle.
  int send_idle_pct = 37;
  int recv_idle_pct = 62;

  int ops_accepted  = 0;
  int beats_checked = 0;
  int mismatches    = 0;
  int error_beats   = 0;
  int full_beats    = 0;
  int empty_beats   = 0;
  int peak_count    = 0;
  int cap_writes    = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Every input of the design is known from time zero; reset is held at
  // the start and then released for the rest of the run.
  initial begin
    in_ch.valid       = 1'b0;
    in_ch.opcode      = OP_INSERT;
    in_ch.in_payload  = '0;
    in_ch.in_priority = '0;
    out_ch.ready      = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Applies one operation to the shadow store and returns the result beat
  // it must produce. The effective capacity clamps zero up to one and large
  // settings down to the depth. A setting below the current count keeps the
  // entries; only inserts are refused until the count drops.
  function automatic queue_result_t predict_queue_op(
    input logic [OPCODE_WIDTH-1:0]      op,
    input logic [31:0]                  pay,
    input logic signed [PRIO_WIDTH-1:0] pri
  );
    queue_result_t res;
    int            room;
    int            pos;
    room = (shadow_cap == 0) ? 1 : (shadow_cap > SLOTS) ? SLOTS : int'(shadow_cap);
    res.status  = ST_OK;
    res.payload = '0;
    res.prio    = '0;
    case (op)
      OP_INSERT: begin
        if (shadow_held >= room || shadow_held >= SLOTS) begin
          res.status = ST_ERROR;
        end else begin
          // Walk past every entry with priority not greater than the new one,
          // so that ties stay in arrival order.
          pos = 0;
          while (pos < shadow_held && !(shadow_prio[pos] > pri)) pos++;
          for (int i = shadow_held; i > pos; i--) begin
            shadow_payload[i] = shadow_payload[i-1];
            shadow_prio[i]    = shadow_prio[i-1];
          end
          shadow_payload[pos] = pay;
          shadow_prio[pos]    = pri;
          shadow_held++;
        end
      end
      OP_REMOVE, OP_PEEK: begin
        if (shadow_held == 0) begin
          res.status = ST_ERROR;
        end else begin
          res.payload = shadow_payload[0];
          res.prio    = shadow_prio[0];
          if (op == OP_REMOVE) begin
            for (int i = 0; i + 1 < shadow_held; i++) begin
              shadow_payload[i] = shadow_payload[i+1];
              shadow_prio[i]    = shadow_prio[i+1];
            end
            shadow_held--;
          end
        end
      end
      default: res.status = ST_ERROR;
    endcase
    res.count = shadow_held[CAP_WIDTH-1:0];
    res.empty = (shadow_held == 0);
    res.full  = (shadow_held >= room);
    return res;
  endfunction

  // Sender. Each accepted beat is predicted at once; a new beat is offered
  // when the channel is free, unless the sender chooses to idle this cycle.
  always @(posedge clk) begin : drive_ops
    queue_op_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        awaited_results.push_back(
          predict_queue_op(in_ch.opcode, in_ch.in_payload, in_ch.in_priority));
        ops_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (queued_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = queued_ops.pop_front();
          in_ch.opcode      <= nxt.opcode;
          in_ch.in_payload  <= nxt.payload;
          in_ch.in_priority <= nxt.prio;
          in_ch.valid       <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Stalls at random, and throughout while a long hold is on.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_results && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long output hold while the sender keeps offering beats, so the design
  // backs up and has to drop ready on its input side.
  initial begin
    while (ops_accepted < 100) @(posedge clk);
    hold_results <= 1'b1;
    repeat (150) @(posedge clk);
    hold_results <= 1'b0;
  end

  task automatic check_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, fname, want, got);
    end
  endtask

  // Monitor. Every result beat is matched against the oldest prediction.
  always @(posedge clk) begin : check_results
    queue_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat: expected none, actual status %b count %0d",
                 $time, out_ch.status, out_ch.entry_count);
      end else begin
        want = awaited_results.pop_front();
        beats_checked++;
        check_field("status", 64'(want.status), 64'(out_ch.status));
        check_field("out_payload", 64'(want.payload), 64'(out_ch.out_payload));
        check_field("out_priority", want.prio, out_ch.out_priority);
        check_field("entry_count", 64'(want.count), 64'(out_ch.entry_count));
        check_field("is_empty", 64'(want.empty), 64'(out_ch.is_empty));
        check_field("is_full", 64'(want.full), 64'(out_ch.is_full));
        if (want.status == ST_ERROR) error_beats++;
        if (want.full) full_beats++;
        if (want.empty) empty_beats++;
        if (int'(want.count) > peak_count) peak_count = int'(want.count);
      end
    end
  end

  task automatic add_op(input logic [OPCODE_WIDTH-1:0] op, input logic [31:0] pay,
                        input logic signed [PRIO_WIDTH-1:0] pri);
    queued_ops.push_back('{op, pay, pri});
  endtask

  // Returns once nothing is queued, offered or owed. Checked on the falling
  // edge so that every update of the rising edge has settled.
  task automatic wait_until_idle();
    @(negedge clk);
    while (queued_ops.size() != 0 || in_ch.valid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Only called while the design is idle, so the shadow copy can follow
  // the register at once.
  task automatic write_capacity(input logic [CAP_WIDTH-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    shadow_cap = value;
    cap_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Filling stretches favor inserts to reach full; draining stretches favor
  // removes to reach empty. The unused opcode shows up now and then in both.
  function automatic logic [OPCODE_WIDTH-1:0] pick_op(input bit filling);
    int r;
    r = $urandom_range(99);
    if (r < (filling ? 60 : 25)) return OP_INSERT;
    if (r < 75) return OP_REMOVE;
    if (r < 95) return OP_PEEK;
    return OP_UNUSED;
  endfunction

  // Half the time a narrow band of priorities so that ties are common, plus the
  // extremes and fully random 64-bit values.
  function automatic logic signed [PRIO_WIDTH-1:0] pick_prio();
    int r;
    r = $urandom_range(9);
    if (r < 5) return PRIO_WIDTH'($signed($urandom_range(6)) - 3);
    if (r == 5) return PRIO_MIN;
    if (r == 6) return PRIO_MAX;
    return {$urandom, $urandom};
  endfunction

  task automatic run_random(input logic [CAP_WIDTH-1:0] cap, input int s_idle,
                            input int r_idle, input int n);
    wait_until_idle();
    write_capacity(cap);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int i = 0; i < n; i++) begin
      add_op(pick_op(((i / 24) % 2) == 0), $urandom, pick_prio());
    end
  endtask

  // Main sequence: a directed opening, then random phases at several
  // capacities and stall mixes, then the verdict.
  initial begin
    while (!rst_n) @(posedge clk);

    // Empty queue errors and the unused opcode, then inserts at the priority
    // and payload extremes with a tie at zero.
    add_op(OP_REMOVE, 32'h0, '0);
    add_op(OP_PEEK, 32'h0, '0);
    add_op(OP_UNUSED, 32'hFFFF_FFFF, PRIO_MAX);
    add_op(OP_INSERT, 32'hFFFF_FFFF, PRIO_MAX);
    add_op(OP_INSERT, 32'h0, PRIO_MIN);
    add_op(OP_INSERT, 32'h1, '0);
    add_op(OP_INSERT, 32'h2, '0);
    add_op(OP_INSERT, 32'h3, -64'sd1);
    add_op(OP_PEEK, 32'h0, '0);
    add_op(OP_UNUSED, 32'h0, PRIO_MIN);

    // Capacity lowered below the count: inserts fail, removes still work
    // and the tie at zero must leave in arrival order.
    wait_until_idle();
    write_capacity(CAP_WIDTH'(2));
    add_op(OP_INSERT, 32'h4, '0);
    add_op(OP_REMOVE, 32'h0, '0);
    add_op(OP_REMOVE, 32'h0, '0);
    add_op(OP_REMOVE, 32'h0, '0);
    add_op(OP_INSERT, 32'h4, '0);
    add_op(OP_REMOVE, 32'h0, '0);
    add_op(OP_INSERT, 32'h5, PRIO_MAX);
    add_op(OP_REMOVE, 32'h0, '0);
    add_op(OP_REMOVE, 32'h0, '0);
    add_op(OP_REMOVE, 32'h0, '0);

    // A capacity of zero acts as one.
    wait_until_idle();
    write_capacity(CAP_WIDTH'(0));
    add_op(OP_INSERT, 32'hA5A5_5A5A, 64'sd7);
    add_op(OP_INSERT, 32'h5A5A_A5A5, 64'sd7);
    add_op(OP_PEEK, 32'h0, '0);

    // A capacity above the depth acts as the depth.
    wait_until_idle();
    write_capacity(CAP_WIDTH'(31));
    add_op(OP_INSERT, 32'h1234_5678, -64'sd5);
    add_op(OP_REMOVE, 32'h0, '0);

    // Random phases: first the sender idles less than the receiver, then
    // the other way round, then neither idles.
    run_random(CAP_WIDTH'(16), 37, 62, 200);
    run_random(CAP_WIDTH'(1),  37, 62, 200);
    run_random(CAP_WIDTH'(31), 62, 37, 200);
    run_random(CAP_WIDTH'(0),  62, 37, 200);
    run_random(CAP_WIDTH'(9),  62, 37, 200);
    run_random(CAP_WIDTH'(16), 0, 0, 220);
    run_random(CAP_WIDTH'(3),  0, 0, 200);

    wait_until_idle();
    repeat (10) @(posedge clk);

    $display("Checked %0d result beats for %0d operations; %0d error results, %0d at full, %0d at empty, peak count %0d.",
             beats_checked, ops_accepted, error_beats, full_beats, empty_beats, peak_count);
    $display("Capacity was written %0d times, including zero and values above the depth, with stalls on both sides and one long output hold.",
             cap_writes);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("** stable_priority_queue: PASSED **");
    end else begin
      $display("** stable_priority_queue: FAILED **");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #1000000;
    $display("** stable_priority_queue: FAILED **");
    $finish;
  end

endmodule

// ===== stable_priority_queue.f =====
hw/rtl/spq_pkg.sv
hw/rtl/spq_in_if.sv
hw/rtl/spq_out_if.sv
hw/rtl/spq_cell.sv
hw/rtl/stable_priority_queue.sv
test/stable_priority_queue_tb.sv
